// ===== design/atpse_pkg.sv =====
// ============================================================================
// atpse_pkg: shared types and constants of the angle tracking pll
// Register indexes, reset values, serial multiplier sizing and the
// request and configuration bundles passed between the modules.
// ============================================================================
`default_nettype none

package atpse_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_BANDWIDTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD  = 1'b1;
    localparam int CFG_DATA_W = 32;

    // register reset values
    localparam logic [15:0] LOOP_BW_RESET       = 16'd1000;
    localparam logic [31:0] SAMPLE_PERIOD_RESET = 32'd214748;

    // item commands
    localparam logic CMD_TRACK   = 1'b0;
    localparam logic CMD_PRELOAD = 1'b1;

    // digit-serial multiplier: 64-bit multiplicand, 32-bit multiplier,
    // one 4-bit multiplier digit per cycle
    localparam int DIGIT_W  = 4;
    localparam int MCAND_W  = 64;
    localparam int MPLIER_W = 32;
    localparam int PROD_W   = MCAND_W + MPLIER_W;
    localparam int SUM_W    = MCAND_W + DIGIT_W;
    localparam int CNT_W    = 4;
    localparam logic [CNT_W-1:0] DIGITS_LONG  = CNT_W'(MPLIER_W / DIGIT_W);
    localparam logic [CNT_W-1:0] DIGITS_SHORT = CNT_W'(16 / DIGIT_W);

    // limits of the speed path
    localparam logic [48:0] DMAG_MAX  = {1'b1, 48'h0};
    localparam logic [47:0] SPEED_MAX = {1'b0, {47{1'b1}}};
    localparam logic [47:0] SPEED_MIN = {1'b1, 47'h0};

    // configuration register contents
    typedef struct packed {
        logic [15:0] loop_bandwidth;
        logic [31:0] sample_period;
    } t_cfg;

    // request to the serial multiplier; a short request has a 16-bit
    // multiplier and returns its product shifted up by 16 bits
    typedef struct packed {
        logic                start;
        logic                is_short;
        logic [MCAND_W-1:0]  mcand;
        logic [MPLIER_W-1:0] mplier;
    } t_mul_req;

endpackage

`default_nettype wire

// ===== design/atpse_cfg.sv =====
// ============================================================================
// atpse_cfg: configuration registers
// Holds loop bandwidth and sample period, written through a valid/ready
// channel that is always ready.
// ============================================================================
`default_nettype none

module atpse_cfg (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [atpse_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [atpse_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output atpse_pkg::t_cfg                       o_cfg
);

    logic [15:0] r_loop_bandwidth;
    logic [31:0] r_sample_period;

    // writes are taken in any cycle
    assign o_cfg_ready = 1'b1;

    // register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loop_bandwidth <= atpse_pkg::LOOP_BW_RESET;
            r_sample_period  <= atpse_pkg::SAMPLE_PERIOD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                atpse_pkg::CFG_LOOP_BANDWIDTH: begin
                    r_loop_bandwidth <= i_cfg_data[15:0];
                end
                atpse_pkg::CFG_SAMPLE_PERIOD: begin
                    r_sample_period <= i_cfg_data[31:0];
                end
                default: begin
                    r_loop_bandwidth <= r_loop_bandwidth;
                end
            endcase
        end
    end

    assign o_cfg.loop_bandwidth = r_loop_bandwidth;
    assign o_cfg.sample_period  = r_sample_period;

endmodule

`default_nettype wire

// ===== design/atpse_mul.sv =====
// ============================================================================
// atpse_mul: digit-serial multiplier
// Shift-add multiplier taking one 4-bit multiplier digit per cycle, lsb
// first; the accumulator shifts right so the adder stays 68 bits wide.
// ============================================================================
`default_nettype none

module atpse_mul (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire atpse_pkg::t_mul_req           i_req,
    output logic                               o_done,
    output logic [atpse_pkg::PROD_W-1:0]       o_product
);

    localparam int DIGIT_W  = atpse_pkg::DIGIT_W;
    localparam int MCAND_W  = atpse_pkg::MCAND_W;
    localparam int MPLIER_W = atpse_pkg::MPLIER_W;
    localparam int PROD_W   = atpse_pkg::PROD_W;
    localparam int SUM_W    = atpse_pkg::SUM_W;
    localparam int CNT_W    = atpse_pkg::CNT_W;

    logic [PROD_W-1:0]         r_acc;
    logic [MCAND_W-1:0]        r_mcand;
    logic [MPLIER_W-1:0]       r_mplier;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_done;
    logic [SUM_W-1:0]          w_partial;
    logic [SUM_W-1:0]          w_sum;
    logic [PROD_W+DIGIT_W-1:0] w_shift;

    // one digit step: add multiplicand times digit at the top, shift right
    assign w_partial = SUM_W'(r_mcand) * SUM_W'(r_mplier[DIGIT_W-1:0]);
    assign w_sum     = SUM_W'(r_acc[PROD_W-1:MPLIER_W]) + w_partial;
    assign w_shift   = {w_sum, r_acc[MPLIER_W-1:0]};

    // step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_req.start) begin
            r_cnt  <= i_req.is_short ? atpse_pkg::DIGITS_SHORT : atpse_pkg::DIGITS_LONG;
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - CNT_W'(1);
            r_done <= (r_cnt == CNT_W'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    // operand and accumulator datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc    <= '0;
            r_mcand  <= i_req.mcand;
            r_mplier <= i_req.mplier;
        end else if (r_cnt != '0) begin
            r_acc    <= w_shift[PROD_W+DIGIT_W-1:DIGIT_W];
            r_mplier <= r_mplier >> DIGIT_W;
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

`default_nettype wire

// ===== design/angle_tracking_pll_speed_estimator_top.sv =====
// ============================================================================
// angle_tracking_pll_speed_estimator_top: second-order angle tracking pll
// Tracking item: its result takes four passes through the 4-bit serial
// multiplier; a new item is only taken after the result is loaded.
// Preload item: goes straight to the done state to load its result.
// A finished result waits in the output register while the next item runs.
// Synchronous reset clears the angle and speed and restores the registers.
// ============================================================================
`default_nettype none

module angle_tracking_pll_speed_estimator_top (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // configuration channel
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [atpse_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [atpse_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input items
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic                             i_cmd,
    input  wire logic [15:0]                      i_measured_angle,
    // result items
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic signed [47:0]                    o_speed_estimate,
    output logic [15:0]                           o_tracked_angle
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_ERR   = 4'd1;
    localparam logic [3:0] S_MUL_E = 4'd2;
    localparam logic [3:0] S_MUL_F = 4'd3;
    localparam logic [3:0] S_MUL_G = 4'd4;
    localparam logic [3:0] S_SPD   = 4'd5;
    localparam logic [3:0] S_W     = 4'd6;
    localparam logic [3:0] S_WMAG  = 4'd7;
    localparam logic [3:0] S_MUL_A = 4'd8;
    localparam logic [3:0] S_ANG   = 4'd9;
    localparam logic [3:0] S_DONE  = 4'd10;

    atpse_pkg::t_cfg     w_cfg;
    atpse_pkg::t_mul_req w_mul_req;
    logic                w_mul_done;
    logic [atpse_pkg::PROD_W-1:0] w_product;

    logic [3:0]  r_state, n_state;
    logic [31:0] r_angle;
    logic [47:0] r_speed;
    logic [31:0] r_d;
    logic        r_err_neg;
    logic [47:0] r_e;
    logic [48:0] r_dmag;
    logic [50:0] r_w;
    logic [31:0] r_a32;
    logic        r_out_valid;
    logic [47:0] r_out_speed;
    logic [15:0] r_out_angle;

    logic        w_in_acc;
    logic        w_out_acc;
    logic        w_out_load;
    logic [31:0] w_err_mag;
    logic [63:0] w_dround;
    logic [49:0] w_spd_sum;
    logic [47:0] w_spd_sat;
    logic [50:0] w_w_next;
    logic [50:0] w_w_abs;

    atpse_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    atpse_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_mul_req),
        .o_done    (w_mul_done),
        .o_product (w_product)
    );

    // handshakes
    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_out_acc  = r_out_valid && !i_out_stall;
    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    // wrapped phase error magnitude, half a turn gives 2^31
    assign w_err_mag = r_d[31] ? (32'd0 - r_d) : r_d;

    // integral step rounded half up and clamped to 2^48
    assign w_dround = w_product[95:32] + {63'd0, w_product[31]};

    // speed update with saturation
    assign w_spd_sum = r_err_neg ? ({{2{r_speed[47]}}, r_speed} - {1'b0, r_dmag})
                                 : ({{2{r_speed[47]}}, r_speed} + {1'b0, r_dmag});
    always_comb begin
        if (w_spd_sum[49:47] == 3'b000 || w_spd_sum[49:47] == 3'b111) begin
            w_spd_sat = w_spd_sum[47:0];
        end else if (w_spd_sum[49]) begin
            w_spd_sat = atpse_pkg::SPEED_MIN;
        end else begin
            w_spd_sat = atpse_pkg::SPEED_MAX;
        end
    end

    // proportional path: w = speed +/- 2*bw*err
    assign w_w_next = r_err_neg ? ({{3{r_speed[47]}}, r_speed} - {2'b00, r_e, 1'b0})
                                : ({{3{r_speed[47]}}, r_speed} + {2'b00, r_e, 1'b0});
    assign w_w_abs  = r_w[50] ? (51'd0 - r_w) : r_w;

    // multiplier requests: err*bw, (err*bw)*bw, (err*bw*bw)*ts, |w|*ts
    always_comb begin
        w_mul_req          = '0;
        w_mul_req.is_short = 1'b1;
        unique case (r_state)
            S_ERR: begin
                w_mul_req.start  = 1'b1;
                w_mul_req.mcand  = {32'd0, w_err_mag};
                w_mul_req.mplier = {16'd0, w_cfg.loop_bandwidth};
            end
            S_MUL_E: begin
                w_mul_req.start  = w_mul_done;
                w_mul_req.mcand  = {16'd0, w_product[63:16]};
                w_mul_req.mplier = {16'd0, w_cfg.loop_bandwidth};
            end
            S_MUL_F: begin
                w_mul_req.start    = w_mul_done;
                w_mul_req.is_short = 1'b0;
                w_mul_req.mcand    = w_product[79:16];
                w_mul_req.mplier   = w_cfg.sample_period;
            end
            S_WMAG: begin
                w_mul_req.start    = 1'b1;
                w_mul_req.is_short = 1'b0;
                w_mul_req.mcand    = {14'd0, w_w_abs[49:0]};
                w_mul_req.mplier   = w_cfg.sample_period;
            end
            default: begin
                w_mul_req.start = 1'b0;
            end
        endcase
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = (i_cmd == atpse_pkg::CMD_PRELOAD) ? S_DONE : S_ERR;
                end
            end
            S_ERR:   n_state = S_MUL_E;
            S_MUL_E: if (w_mul_done) n_state = S_MUL_F;
            S_MUL_F: if (w_mul_done) n_state = S_MUL_G;
            S_MUL_G: if (w_mul_done) n_state = S_SPD;
            S_SPD:   n_state = S_W;
            S_W:     n_state = S_WMAG;
            S_WMAG:  n_state = S_MUL_A;
            S_MUL_A: if (w_mul_done) n_state = S_ANG;
            S_ANG:   n_state = S_DONE;
            S_DONE:  if (w_out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control state, loop state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_angle     <= '0;
            r_speed     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_acc && i_cmd == atpse_pkg::CMD_PRELOAD) begin
                r_angle <= {i_measured_angle, 16'h0000};
                r_speed <= '0;
            end
            if (r_state == S_SPD) begin
                r_speed <= w_spd_sat;
            end
            if (r_state == S_ANG) begin
                r_angle <= r_w[50] ? (r_angle - r_a32) : (r_angle + r_a32);
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (w_out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // intermediate values and output payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_d <= {i_measured_angle, 16'h0000} - r_angle;
        end
        if (r_state == S_ERR) begin
            r_err_neg <= r_d[31];
        end
        if (r_state == S_MUL_E && w_mul_done) begin
            r_e <= w_product[63:16];
        end
        if (r_state == S_MUL_G && w_mul_done) begin
            r_dmag <= (w_dround > {15'd0, atpse_pkg::DMAG_MAX}) ? atpse_pkg::DMAG_MAX
                                                                : w_dround[48:0];
        end
        if (r_state == S_W) begin
            r_w <= w_w_next;
        end
        if (r_state == S_MUL_A && w_mul_done) begin
            r_a32 <= w_product[63:32] + {31'd0, w_product[31]};
        end
        if (w_out_load) begin
            r_out_speed <= r_speed;
            r_out_angle <= r_angle[31:16];
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_speed_estimate = signed'(r_out_speed);
    assign o_tracked_angle  = r_out_angle;

endmodule

`default_nettype wire

// ===== design/atpse_checker.sv =====
// ============================================================================
// atpse_checker: port-level checks of the angle tracking pll
// Watches the top level ports for handshake holding, busy signalling and
// the preload result timing; bound to the top level.
// ============================================================================
`default_nettype none

module atpse_checker (
    input wire logic                             i_clk,
    input wire logic                             i_rst_n,
    input wire logic                             i_in_valid,
    input wire logic                             o_in_stall,
    input wire logic                             i_cmd,
    input wire logic [15:0]                      i_measured_angle,
    input wire logic                             o_out_valid,
    input wire logic                             i_out_stall,
    input wire logic signed [47:0]               o_speed_estimate,
    input wire logic [15:0]                      o_tracked_angle
);

    logic w_in_acc;

    assign w_in_acc = i_in_valid && !o_in_stall;

    // a stalled result item stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result item dropped while stalled");

    // an accepted item keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_in_stall)
        else $error("input taken again right after an item");

    // a result only appears at the end of an item's work
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result item without work in progress");

    // preload gives zero speed and the measured angle as its result
    a_preload_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_cmd == atpse_pkg::CMD_PRELOAD && !o_out_valid |-> ##2
        (!$past(i_rst_n) || (o_out_valid && o_speed_estimate == 48'sd0 &&
         o_tracked_angle == $past(i_measured_angle, 2))))
        else $error("preload item gave a wrong result");

endmodule

bind angle_tracking_pll_speed_estimator_top atpse_checker u_atpse_checker (.*);

`default_nettype wire
